>>> rtl/mbr_pkg.sv
// ----------------------------------------------------------------------------
// MPPT boost regulator package
// Shared types, register codes and reset values for the regulator block.
// ----------------------------------------------------------------------------
package mbr_pkg;

    // Field widths of the regulation tick and of the result
    localparam int AdcWidth   = 12;
    localparam int GearWidth  = 8;
    localparam int TimerWidth = 16;
    localparam int PowerWidth = 2 * AdcWidth;
    localparam int AccWidth   = 32;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 16;

    // Defaults for the top-level parameters
    localparam int DefAvgExp        = 4;
    localparam int DefGearMax       = 255;
    localparam int DefOverloadTicks = 100;
    localparam int DefStoppingTicks = 100;
    localparam int DefFlareTicks    = 1000;

    // Configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_BATTERY_CURRENT_LIMIT = 3'd0,
        CFG_BATTERY_VOLTAGE_LIMIT = 3'd1,
        CFG_STOP_PANEL_CURRENT    = 3'd2,
        CFG_START_PANEL_VOLTAGE   = 3'd3,
        CFG_MIN_PANEL_VOLTAGE     = 3'd4,
        CFG_MAX_PANEL_VOLTAGE     = 3'd5,
        CFG_PERTURB_STEP          = 3'd6,
        CFG_SETTLE_TICKS          = 3'd7
    } mbr_cfg_index_t;

    // Configuration reset values
    localparam logic [AdcWidth-1:0]   RstBatteryCurrentLimit = 12'd4095;
    localparam logic [AdcWidth-1:0]   RstBatteryVoltageLimit = 12'd4095;
    localparam logic [AdcWidth-1:0]   RstStopPanelCurrent    = 12'd0;
    localparam logic [AdcWidth-1:0]   RstStartPanelVoltage   = 12'd2048;
    localparam logic [AdcWidth-1:0]   RstMinPanelVoltage     = 12'd0;
    localparam logic [AdcWidth-1:0]   RstMaxPanelVoltage     = 12'd4095;
    localparam logic [AdcWidth-1:0]   RstPerturbStep         = 12'd16;
    localparam logic [TimerWidth-1:0] RstSettleTicks         = 16'd100;

    // One regulation tick held in the input register, with its panel power
    typedef struct packed {
        logic [AdcWidth-1:0]   panel_voltage;
        logic [AdcWidth-1:0]   panel_current;
        logic [AdcWidth-1:0]   battery_voltage;
        logic [AdcWidth-1:0]   battery_current;
        logic                  converter_stopped;
        logic [PowerWidth-1:0] power;
    } mbr_item_t;

endpackage

>>> rtl/mppt_boost_regulator.sv
// ----------------------------------------------------------------------------
// MPPT boost regulator
// Perturb-and-observe maximum power point tracker that also steps the gear
// of a bridge-type boost converter, one regulation tick per item.
// ----------------------------------------------------------------------------
// Takes one item every clock cycle unless a stalled result holds the input,
// and returns exactly one result per item. The first register captures the
// tick and the panel power product; the update logic behind it runs the
// optimizer, fault timers and gear update against the block state and loads
// the result register, where the result is held until taken. The result
// register doubles as the output buffer, so a stalled result holds the next
// item in the input register and no further.
// Configuration writes take effect on the next item and are meant to be made
// while no item is in flight. After a stopped-converter tick only
// reset_request is raised; the gear and target are reported unchanged.
// ----------------------------------------------------------------------------
module mppt_boost_regulator #(
    parameter int AVG_EXP        = mbr_pkg::DefAvgExp,
    parameter int GEAR_MAX       = mbr_pkg::DefGearMax,
    parameter int OVERLOAD_TICKS = mbr_pkg::DefOverloadTicks,
    parameter int STOPPING_TICKS = mbr_pkg::DefStoppingTicks,
    parameter int FLARE_TICKS    = mbr_pkg::DefFlareTicks
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [mbr_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [mbr_pkg::CfgDataWidth-1:0]     cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mbr_pkg::AdcWidth-1:0]         panel_voltage,
    input  logic [mbr_pkg::AdcWidth-1:0]         panel_current,
    input  logic [mbr_pkg::AdcWidth-1:0]         battery_voltage,
    input  logic [mbr_pkg::AdcWidth-1:0]         battery_current,
    input  logic                                 converter_stopped,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mbr_pkg::GearWidth-1:0]        gear_number,
    output logic [mbr_pkg::AdcWidth-1:0]         target_voltage,
    output logic                                 stop_request,
    output logic                                 reset_request,
    output logic                                 power_limited
);

    localparam int Aw = mbr_pkg::AdcWidth;
    localparam int Tw = mbr_pkg::TimerWidth;
    localparam int Pw = mbr_pkg::PowerWidth;
    localparam int Cw = mbr_pkg::AccWidth;
    localparam int Gw = mbr_pkg::GearWidth;

    localparam logic [Tw:0]    Rounds     = (Tw+1)'(1 << AVG_EXP);
    localparam logic [Gw+1:0]  GearMaxExt = (Gw+2)'(GEAR_MAX);
    localparam logic signed [Gw+1:0] GearStep = (Gw+2)'(1);
    localparam logic [Tw-1:0]  OverloadT  = Tw'(OVERLOAD_TICKS);
    localparam logic [Tw-1:0]  StoppingT  = Tw'(STOPPING_TICKS);
    localparam logic [Tw-1:0]  FlareT     = Tw'(FLARE_TICKS);
    localparam logic [Pw-1:0]  AvgMax     = '1;

    // Configuration registers
    logic [Aw-1:0] bat_i_limit_reg;
    logic [Aw-1:0] bat_v_limit_reg;
    logic [Aw-1:0] stop_i_reg;
    logic [Aw-1:0] start_v_reg;
    logic [Aw-1:0] min_v_reg;
    logic [Aw-1:0] max_v_reg;
    logic [Aw-1:0] step_size_reg;
    logic [Tw-1:0] settle_reg;

    // Input stage
    mbr_pkg::mbr_item_t item_reg;
    logic               item_valid_reg;
    logic               advance;
    logic               in_fire;
    logic               item_fire;

    // Block state
    logic [Tw-1:0]        opt_timer_reg,  opt_timer_next;
    logic [Cw-1:0]        acc_reg,        acc_next;
    logic [Pw-1:0]        last_power_reg, last_power_next;
    logic signed [Aw:0]   step_reg,       step_next;
    logic [Aw-1:0]        target_reg,     target_next;
    logic [Gw-1:0]        gear_reg,       gear_next;
    logic [Tw-1:0]        overload_reg,   overload_next;
    logic [Tw-1:0]        stopping_reg,   stopping_next;
    logic [Tw-1:0]        limit_reg,      limit_next;

    // Result flags
    logic out_valid_reg;
    logic stop_req_reg,  stop_req_next;
    logic reset_req_reg, reset_req_next;
    logic limited_reg,   limited_next;

    // Update datapath
    logic [Tw-1:0]        ot_inc;
    logic [Tw:0]          round_end;
    logic [Cw:0]          acc_sum;
    logic [Cw-1:0]        acc_sat;
    logic [Cw-1:0]        avg_full;
    logic [Pw-1:0]        avg_sat;
    logic signed [Aw:0]   step_new;
    logic signed [Aw+1:0] target_sum;
    logic [Aw-1:0]        opt_target;
    logic signed [Gw+1:0] gear_work;
    logic [Tw-1:0]        limit_set;
    logic                 overload;
    logic                 under_current;

    // Handshake: the result register is the only buffer after the input stage
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = item_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;
    assign item_fire = item_valid_reg && advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_i_limit_reg <= mbr_pkg::RstBatteryCurrentLimit;
            bat_v_limit_reg <= mbr_pkg::RstBatteryVoltageLimit;
            stop_i_reg      <= mbr_pkg::RstStopPanelCurrent;
            start_v_reg     <= mbr_pkg::RstStartPanelVoltage;
            min_v_reg       <= mbr_pkg::RstMinPanelVoltage;
            max_v_reg       <= mbr_pkg::RstMaxPanelVoltage;
            step_size_reg   <= mbr_pkg::RstPerturbStep;
            settle_reg      <= mbr_pkg::RstSettleTicks;
        end
        else if (cfg_write)
        begin
            case (mbr_pkg::mbr_cfg_index_t'(cfg_index))
                mbr_pkg::CFG_BATTERY_CURRENT_LIMIT: bat_i_limit_reg <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_BATTERY_VOLTAGE_LIMIT: bat_v_limit_reg <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_STOP_PANEL_CURRENT:    stop_i_reg      <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_START_PANEL_VOLTAGE:   start_v_reg     <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_MIN_PANEL_VOLTAGE:     min_v_reg       <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_MAX_PANEL_VOLTAGE:     max_v_reg       <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_PERTURB_STEP:          step_size_reg   <= cfg_data[Aw-1:0];
                mbr_pkg::CFG_SETTLE_TICKS:          settle_reg      <= cfg_data[Tw-1:0];
                default:                            ;
            endcase
        end
    end

    // Capture the tick and its panel power
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.panel_voltage     <= panel_voltage;
            item_reg.panel_current     <= panel_current;
            item_reg.battery_voltage   <= battery_voltage;
            item_reg.battery_current   <= battery_current;
            item_reg.converter_stopped <= converter_stopped;
            item_reg.power             <= Pw'(panel_voltage) * Pw'(panel_current);
        end
    end

    // Optimizer: settle, accumulate, then perturb the target once per round
    always_comb
    begin
        ot_inc     = (opt_timer_reg != '1) ? opt_timer_reg + 1'b1 : opt_timer_reg;
        round_end  = {1'b0, settle_reg} + Rounds;
        acc_sum    = {1'b0, acc_reg} + (Cw+1)'(item_reg.power);
        acc_sat    = acc_sum[Cw] ? '1 : acc_sum[Cw-1:0];
        avg_full   = acc_sat >> AVG_EXP;
        avg_sat    = (avg_full > Cw'(AvgMax)) ? AvgMax : avg_full[Pw-1:0];
        if (avg_sat <= last_power_reg)
        begin
            step_new = (step_reg > 0) ? -$signed({1'b0, step_size_reg})
                                      : $signed({1'b0, step_size_reg});
        end
        else
        begin
            step_new = step_reg;
        end
        target_sum = $signed({2'b00, target_reg}) + (Aw+2)'(step_new);
        if (target_sum < $signed({2'b00, min_v_reg}))
        begin
            opt_target = min_v_reg;
        end
        else if (target_sum > $signed({2'b00, max_v_reg}))
        begin
            opt_target = max_v_reg;
        end
        else
        begin
            opt_target = target_sum[Aw-1:0];
        end
    end

    // Tick update: optimizer, fault handling, gear and timers
    always_comb
    begin
        opt_timer_next  = opt_timer_reg;
        acc_next        = acc_reg;
        last_power_next = last_power_reg;
        step_next       = step_reg;
        target_next     = target_reg;
        gear_next       = gear_reg;
        overload_next   = overload_reg;
        stopping_next   = stopping_reg;
        limit_set       = limit_reg;
        stop_req_next   = 1'b0;
        reset_req_next  = 1'b0;
        gear_work       = $signed({2'b00, gear_reg});
        overload        = (item_reg.battery_current > bat_i_limit_reg) ||
                          (item_reg.battery_voltage > bat_v_limit_reg);
        under_current   = item_reg.panel_current < stop_i_reg;

        if (item_reg.converter_stopped)
        begin
            reset_req_next = 1'b1;
        end
        else
        begin
            // optimizer round
            opt_timer_next = ot_inc;
            if (ot_inc > settle_reg)
            begin
                acc_next = acc_sat;
                if ({1'b0, ot_inc} >= round_end)
                begin
                    step_next       = step_new;
                    target_next     = opt_target;
                    last_power_next = avg_sat;
                    acc_next        = '0;
                    opt_timer_next  = '0;
                end
            end

            // faults restart the optimizer; otherwise track the target
            if (overload)
            begin
                gear_work      = gear_work - GearStep;
                acc_next       = '0;
                opt_timer_next = '0;
                target_next    = start_v_reg;
                if (overload_reg != '0)
                begin
                    overload_next = overload_reg - 1'b1;
                end
                else
                begin
                    stop_req_next = 1'b1;
                end
                limit_set = FlareT;
            end
            else
            begin
                overload_next = OverloadT;
                if (under_current)
                begin
                    gear_work      = gear_work + GearStep;
                    acc_next       = '0;
                    opt_timer_next = '0;
                    target_next    = start_v_reg;
                    if (stopping_reg != '0)
                    begin
                        stopping_next = stopping_reg - 1'b1;
                    end
                    else
                    begin
                        stop_req_next = 1'b1;
                    end
                end
                else
                begin
                    stopping_next = StoppingT;
                    if (item_reg.panel_voltage > target_next)
                    begin
                        gear_work = gear_work + GearStep;
                    end
                    else
                    begin
                        gear_work = gear_work - GearStep;
                    end
                end
            end

            // saturate the gear
            if (gear_work < 0)
            begin
                gear_next = '0;
            end
            else if (gear_work > $signed(GearMaxExt))
            begin
                gear_next = GearMaxExt[Gw-1:0];
            end
            else
            begin
                gear_next = gear_work[Gw-1:0];
            end
        end

        // power limitation timer runs on every tick
        limit_next   = (limit_set != '0) ? limit_set - 1'b1 : '0;
        limited_next = limit_next != '0;
    end

    // Commit state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            opt_timer_reg  <= '0;
            acc_reg        <= '0;
            last_power_reg <= '0;
            step_reg       <= '0;
            target_reg     <= mbr_pkg::RstStartPanelVoltage;
            gear_reg       <= '0;
            overload_reg   <= '0;
            stopping_reg   <= '0;
            limit_reg      <= '0;
            stop_req_reg   <= 1'b0;
            reset_req_reg  <= 1'b0;
            limited_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                opt_timer_reg  <= opt_timer_next;
                acc_reg        <= acc_next;
                last_power_reg <= last_power_next;
                step_reg       <= step_next;
                target_reg     <= target_next;
                gear_reg       <= gear_next;
                overload_reg   <= overload_next;
                stopping_reg   <= stopping_next;
                limit_reg      <= limit_next;
                stop_req_reg   <= stop_req_next;
                reset_req_reg  <= reset_req_next;
                limited_reg    <= limited_next;
            end
        end
    end

    // Drive the result ports
    assign out_valid      = out_valid_reg;
    assign gear_number    = gear_reg;
    assign target_voltage = target_reg;
    assign stop_request   = stop_req_reg;
    assign reset_request  = reset_req_reg;
    assign power_limited  = limited_reg;

    // A result never carries both a stop and a reset request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(stop_req_reg && reset_req_reg))
        else $error("stop and reset request raised together");

    // The gear never leaves its saturation range
    assert property (@(posedge clk) disable iff (!rst_n)
        gear_reg <= GearMaxExt[Gw-1:0])
        else $error("gear above maximum");

    // A stopped-converter tick leaves gear and target untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item_reg.converter_stopped) |=>
            (gear_reg == $past(gear_reg)) && (target_reg == $past(target_reg)))
        else $error("stopped tick changed gear or target");

    // The input side stalls only behind a held tick
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline");

endmodule

>>> tb/mbr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MPPT boost regulator checker
// Watches the register port and both item channels of the regulator. It
// keeps its own copy of the tracker state, predicts the result of every
// accepted tick and compares each accepted result, field by field, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module mbr_checker #(
    parameter int AVG_EXP        = mbr_pkg::DefAvgExp,
    parameter int GEAR_MAX       = mbr_pkg::DefGearMax,
    parameter int OVERLOAD_TICKS = mbr_pkg::DefOverloadTicks,
    parameter int STOPPING_TICKS = mbr_pkg::DefStoppingTicks,
    parameter int FLARE_TICKS    = mbr_pkg::DefFlareTicks
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbr_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [mbr_pkg::CfgDataWidth-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [mbr_pkg::AdcWidth-1:0]     panel_voltage,
    input  logic [mbr_pkg::AdcWidth-1:0]     panel_current,
    input  logic [mbr_pkg::AdcWidth-1:0]     battery_voltage,
    input  logic [mbr_pkg::AdcWidth-1:0]     battery_current,
    input  logic                             converter_stopped,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [mbr_pkg::GearWidth-1:0]    gear_number,
    input  logic [mbr_pkg::AdcWidth-1:0]     target_voltage,
    input  logic                             stop_request,
    input  logic                             reset_request,
    input  logic                             power_limited,
    output int                               fail_count,
    output int                               pending,
    output int                               compared
);

    localparam int Rounds = 1 << AVG_EXP;
    localparam int Aw     = mbr_pkg::AdcWidth;
    localparam int Tw     = mbr_pkg::TimerWidth;
    localparam int Gw     = mbr_pkg::GearWidth;
    localparam int Pw     = mbr_pkg::PowerWidth;
    localparam int Cw     = mbr_pkg::AccWidth;

    typedef struct {
        logic [Gw-1:0] gear;
        logic [Aw-1:0] target;
        logic          stop;
        logic          reset;
        logic          limited;
    } regulation_t;

    // Register copies
    logic [Aw-1:0] ibat_limit, vbat_limit, ipan_floor;
    logic [Aw-1:0] start_v, min_v, max_v, step_size;
    logic [Tw-1:0] settle;

    // Tracker state
    logic [Tw-1:0] opt_timer;
    logic [Cw-1:0] power_acc;
    logic [Pw-1:0] prev_power;
    int            step_signed;
    logic [Aw-1:0] target_q;
    logic [Gw-1:0] gear_q;
    logic [Tw-1:0] overload_cnt, stopping_cnt, flare_cnt;

    regulation_t ticks_due[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        compared   = 0;
    end

    // Drop the current averaging round and go back to the start voltage
    task automatic restart_tracking();
        power_acc = '0;
        opt_timer = '0;
        target_q  = start_v;
    endtask

    // One perturb-and-observe step: settle, average power, then move target
    task automatic perturb_observe(input logic [Aw-1:0] vpan,
                                   input logic [Aw-1:0] ipan);
        logic [Pw-1:0] power;
        logic [Cw:0]   sum;
        logic [Cw-1:0] avg;
        int            t;
        if (opt_timer != '1)
            opt_timer = opt_timer + 1'b1;
        if (opt_timer <= settle)
            return;
        power     = vpan * ipan;
        sum       = power_acc + power;
        power_acc = sum[Cw] ? '1 : sum[Cw-1:0];
        if (int'(opt_timer) >= int'(settle) + Rounds) begin
            avg = power_acc >> AVG_EXP;
            if (avg > 32'h00FF_FFFF)
                avg = 32'h00FF_FFFF;
            // flip direction when power did not rise; a zero step starts positive
            if (avg <= {8'h00, prev_power})
                step_signed = (step_signed > 0) ? -int'(step_size) : int'(step_size);
            t = int'(target_q) + step_signed;
            // the minimum is checked first: with crossed limits a target at or above it goes to the maximum
            if (t < int'(min_v))
                t = int'(min_v);
            else if (t > int'(max_v))
                t = int'(max_v);
            target_q   = t[Aw-1:0];
            prev_power = avg[Pw-1:0];
            power_acc  = '0;
            opt_timer  = '0;
        end
    endtask

    // Advance the regulator by one tick and build its result
    task automatic regulate_tick(output regulation_t res);
        int g;
        res.stop  = 1'b0;
        res.reset = 1'b0;
        if (converter_stopped) begin
            res.reset = 1'b1;
        end
        else begin
            g = int'(gear_q);
            perturb_observe(panel_voltage, panel_current);
            if (battery_current > ibat_limit || battery_voltage > vbat_limit) begin
                // battery overload: shed gear, count toward a stop
                g = g - 1;
                restart_tracking();
                if (overload_cnt != 0)
                    overload_cnt = overload_cnt - 1'b1;
                else
                    res.stop = 1'b1;
                flare_cnt = Tw'(FLARE_TICKS);
            end
            else begin
                overload_cnt = Tw'(OVERLOAD_TICKS);
                if (panel_current < ipan_floor) begin
                    // panel under-current: raise gear, count toward a stop
                    g = g + 1;
                    restart_tracking();
                    if (stopping_cnt != 0)
                        stopping_cnt = stopping_cnt - 1'b1;
                    else
                        res.stop = 1'b1;
                end
                else begin
                    stopping_cnt = Tw'(STOPPING_TICKS);
                    if (panel_voltage > target_q)
                        g = g + 1;
                    else
                        g = g - 1;
                end
            end
            if (g < 0)
                g = 0;
            if (g > GEAR_MAX)
                g = GEAR_MAX;
            gear_q = g[Gw-1:0];
        end
        if (flare_cnt != 0)
            flare_cnt = flare_cnt - 1'b1;
        res.gear    = gear_q;
        res.target  = target_q;
        res.limited = (flare_cnt != 0);
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        regulation_t want;
        regulation_t fresh;
        if (!rst_n) begin
            ibat_limit   = mbr_pkg::RstBatteryCurrentLimit;
            vbat_limit   = mbr_pkg::RstBatteryVoltageLimit;
            ipan_floor   = mbr_pkg::RstStopPanelCurrent;
            start_v      = mbr_pkg::RstStartPanelVoltage;
            min_v        = mbr_pkg::RstMinPanelVoltage;
            max_v        = mbr_pkg::RstMaxPanelVoltage;
            step_size    = mbr_pkg::RstPerturbStep;
            settle       = mbr_pkg::RstSettleTicks;
            opt_timer    = '0;
            power_acc    = '0;
            prev_power   = '0;
            step_signed  = 0;
            target_q     = mbr_pkg::RstStartPanelVoltage;
            gear_q       = '0;
            overload_cnt = '0;
            stopping_cnt = '0;
            flare_cnt    = '0;
            ticks_due.delete();
        end
        else begin
            // Register writes should land only while the block is idle; the checker does not enforce it
            if (cfg_write) begin
                case (mbr_pkg::mbr_cfg_index_t'(cfg_index))
                    mbr_pkg::CFG_BATTERY_CURRENT_LIMIT: ibat_limit = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_BATTERY_VOLTAGE_LIMIT: vbat_limit = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_STOP_PANEL_CURRENT:    ipan_floor = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_START_PANEL_VOLTAGE:   start_v    = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_MIN_PANEL_VOLTAGE:     min_v      = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_MAX_PANEL_VOLTAGE:     max_v      = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_PERTURB_STEP:          step_size  = cfg_data[Aw-1:0];
                    mbr_pkg::CFG_SETTLE_TICKS:          settle     = cfg_data;
                    default: ;
                endcase
            end
            // Compare a result before taking a new tick, so that a result
            // never matches the tick accepted at the same edge
            if (out_valid && !out_stall) begin
                if (ticks_due.size() == 0) begin
                    $error("result with no tick outstanding: gear_number %0d, target_voltage %0d",
                           gear_number, target_voltage);
                    fail_count++;
                end
                else begin
                    want = ticks_due.pop_front();
                    flag_field("gear_number", want.gear, gear_number);
                    flag_field("target_voltage", want.target, target_voltage);
                    flag_field("stop_request", want.stop, stop_request);
                    flag_field("reset_request", want.reset, reset_request);
                    flag_field("power_limited", want.limited, power_limited);
                    compared++;
                end
            end
            if (in_valid && !in_stall) begin
                regulate_tick(fresh);
                ticks_due.push_back(fresh);
            end
        end
        pending = ticks_due.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MPPT boost regulator testbench
// Drives regulation ticks and register settings into the regulator, with
// random idle bursts on both channels, while a checker beside the block
// predicts every result. Covers directed edge ticks, fault and gear limits,
// crossed target limits, zero step, and a run at the settle ceiling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 4;
    localparam int Aw            = mbr_pkg::AdcWidth;
    localparam int Tw            = mbr_pkg::TimerWidth;
    localparam int Dw            = mbr_pkg::CfgDataWidth;

    typedef enum int {
        MIX_CLEAN,
        MIX_MIXED,
        MIX_NOISE,
        MIX_CLIMB,
        MIX_SHED
    } tick_mix_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [mbr_pkg::CfgIdxWidth-1:0]     cfg_index = '0;
    logic [Dw-1:0]                       cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [Aw-1:0]                       panel_voltage = '0;
    logic [Aw-1:0]                       panel_current = '0;
    logic [Aw-1:0]                       battery_voltage = '0;
    logic [Aw-1:0]                       battery_current = '0;
    logic                                converter_stopped = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [mbr_pkg::GearWidth-1:0]       gear_number;
    logic [Aw-1:0]                       target_voltage;
    logic                                stop_request;
    logic                                reset_request;
    logic                                power_limited;

    int fail_count;
    int pending;
    int compared;
    int ticks_sent = 0;
    int settings_run = 0;
    int quiet_cycles = 0;
    bit source_idle = 1'b1;
    bit sink_idle = 1'b1;

    logic [Dw-1:0] reg_value [8];

    mppt_boost_regulator DUT (.*);

    mbr_checker u_checker (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    // Receiver stalls in random bursts
    always begin
        @(negedge clk);
        if (sink_idle && $urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one tick, with an optional gap first, and hold it until taken
    task automatic send_tick(input logic [Aw-1:0] vpan, input logic [Aw-1:0] ipan,
                             input logic [Aw-1:0] vbat, input logic [Aw-1:0] ibat,
                             input logic stopped);
        if (source_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        panel_voltage     <= vpan;
        panel_current     <= ipan;
        battery_voltage   <= vbat;
        battery_current   <= ibat;
        converter_stopped <= stopped;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write all eight registers while the block is idle
    task automatic apply_regs(input logic [Aw-1:0] ibat_lim,
                              input logic [Aw-1:0] vbat_lim,
                              input logic [Aw-1:0] ipan_min,
                              input logic [Aw-1:0] start_v,
                              input logic [Aw-1:0] min_v,
                              input logic [Aw-1:0] max_v,
                              input logic [Aw-1:0] step_v,
                              input logic [Tw-1:0] settle_v);
        int            i;
        logic [Dw-1:0] junk;
        reg_value[mbr_pkg::CFG_BATTERY_CURRENT_LIMIT] = ibat_lim;
        reg_value[mbr_pkg::CFG_BATTERY_VOLTAGE_LIMIT] = vbat_lim;
        reg_value[mbr_pkg::CFG_STOP_PANEL_CURRENT]    = ipan_min;
        reg_value[mbr_pkg::CFG_START_PANEL_VOLTAGE]   = start_v;
        reg_value[mbr_pkg::CFG_MIN_PANEL_VOLTAGE]     = min_v;
        reg_value[mbr_pkg::CFG_MAX_PANEL_VOLTAGE]     = max_v;
        reg_value[mbr_pkg::CFG_PERTURB_STEP]          = step_v;
        reg_value[mbr_pkg::CFG_SETTLE_TICKS]          = settle_v;
        wait_drained();
        repeat (DrainCycles) @(negedge clk);
        for (i = 0; i < 8; i++) begin
            // upper bits of the 12-bit registers carry junk that must be dropped
            if (mbr_pkg::mbr_cfg_index_t'(i) == mbr_pkg::CFG_SETTLE_TICKS)
                junk = '0;
            else
                junk = Dw'($urandom_range(0, 15)) << Aw;
            cfg_write <= 1'b1;
            cfg_index <= mbr_pkg::mbr_cfg_index_t'(i);
            cfg_data  <= reg_value[i] | junk;
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        @(negedge clk);
        settings_run++;
    endtask

    task automatic apply_random_regs();
        apply_regs(Aw'($urandom_range(1500, 4095)), Aw'($urandom_range(1500, 4095)),
                   Aw'($urandom_range(0, 800)), Aw'($urandom_range(0, 4095)),
                   Aw'($urandom_range(0, 2000)), Aw'($urandom_range(2000, 4095)),
                   Aw'($urandom_range(0, 600)), Tw'($urandom_range(0, 12)));
    endtask

    // Send a run of random ticks shaped by the chosen mix
    task automatic run_ticks(input tick_mix_t mix, input int count);
        int            n;
        logic          noisy;
        logic [Aw-1:0] vpan, ipan, vbat, ibat;
        logic          stopped;
        logic [Aw-1:0] ibat_lim, vbat_lim, ipan_min;
        ibat_lim = reg_value[mbr_pkg::CFG_BATTERY_CURRENT_LIMIT][Aw-1:0];
        vbat_lim = reg_value[mbr_pkg::CFG_BATTERY_VOLTAGE_LIMIT][Aw-1:0];
        ipan_min = reg_value[mbr_pkg::CFG_STOP_PANEL_CURRENT][Aw-1:0];
        for (n = 0; n < count; n++) begin
            // well-formed tick: no fault, converter running
            vpan    = Aw'($urandom_range(0, 4095));
            ipan    = Aw'($urandom_range(ipan_min, 4095));
            vbat    = Aw'($urandom_range(0, vbat_lim));
            ibat    = Aw'($urandom_range(0, ibat_lim));
            stopped = 1'b0;
            noisy   = (mix == MIX_NOISE) || (mix == MIX_MIXED && $urandom_range(0, 9) == 0);
            if (noisy) begin
                ipan    = Aw'($urandom);
                vbat    = Aw'($urandom);
                ibat    = Aw'($urandom);
                stopped = 1'($urandom_range(0, 1));
            end
            else if (mix == MIX_CLIMB && $urandom_range(0, 39) != 0) begin
                ipan = (ipan_min == 0) ? '0 : Aw'($urandom_range(0, ipan_min - 1));
            end
            else if (mix == MIX_SHED && $urandom_range(0, 39) != 0) begin
                vbat = Aw'($urandom);
                ibat = (ibat_lim == '1) ? '1 : Aw'($urandom_range(ibat_lim + 1, 4095));
            end
            send_tick(vpan, ipan, vbat, ibat, stopped);
        end
    endtask

    initial begin
        int k;
        reg_value[mbr_pkg::CFG_BATTERY_CURRENT_LIMIT] = mbr_pkg::RstBatteryCurrentLimit;
        reg_value[mbr_pkg::CFG_BATTERY_VOLTAGE_LIMIT] = mbr_pkg::RstBatteryVoltageLimit;
        reg_value[mbr_pkg::CFG_STOP_PANEL_CURRENT]    = mbr_pkg::RstStopPanelCurrent;
        reg_value[mbr_pkg::CFG_START_PANEL_VOLTAGE]   = mbr_pkg::RstStartPanelVoltage;
        reg_value[mbr_pkg::CFG_MIN_PANEL_VOLTAGE]     = mbr_pkg::RstMinPanelVoltage;
        reg_value[mbr_pkg::CFG_MAX_PANEL_VOLTAGE]     = mbr_pkg::RstMaxPanelVoltage;
        reg_value[mbr_pkg::CFG_PERTURB_STEP]          = mbr_pkg::RstPerturbStep;
        reg_value[mbr_pkg::CFG_SETTLE_TICKS]          = mbr_pkg::RstSettleTicks;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks: stopped converter, both overloads, under-current,
        // zero timers, field extremes and limit boundaries
        apply_regs(3000, 3500, 100, 2048, 1000, 3000, 4095, 0);
        send_tick(0, 0, 0, 0, 1'b0);
        send_tick(4095, 4095, 4095, 4095, 1'b1);
        send_tick(4095, 4095, 4095, 4095, 1'b0);
        send_tick(2000, 500, 100, 3001, 1'b0);
        send_tick(2000, 500, 3501, 100, 1'b0);
        send_tick(2000, 99, 100, 100, 1'b0);
        send_tick(4095, 100, 3500, 3000, 1'b0);
        send_tick(0, 4095, 0, 0, 1'b0);
        send_tick(0, 0, 0, 0, 1'b1);
        // one full averaging round at peak power: a zero step stays zero
        for (k = 0; k < 16; k++)
            send_tick(4095, 4095, 0, 0, 1'b0);

        // Reset-like limits with a short settle
        apply_regs(4095, 4095, 0, 2048, 0, 4095, 16, 3);
        run_ticks(MIX_CLEAN, 100);

        // Random settings, with one full drain in the middle
        apply_random_regs();
        run_ticks(MIX_MIXED, 60);
        wait_drained();
        run_ticks(MIX_MIXED, 60);

        // Crossed target limits with the largest step
        apply_regs(4095, 4095, 0, 4095, 3000, 1000, 4095, 0);
        run_ticks(MIX_CLEAN, 50);

        // Zero step from a zero start voltage
        apply_regs(4095, 4095, 0, 0, 0, 4095, 0, 1);
        run_ticks(MIX_CLEAN, 40);

        // Under-current climb to the top gear and stopping timeouts
        apply_regs(4095, 4095, 4095, 2048, 0, 4095, 16, 100);
        run_ticks(MIX_CLIMB, 300);

        // Overload from zero limits down to gear zero and overload timeouts
        apply_regs(0, 0, 0, 2048, 0, 4095, 16, 0);
        run_ticks(MIX_SHED, 300);

        apply_random_regs();
        run_ticks(MIX_NOISE, 60);

        // Last part without idling: settle ceiling, then random settings
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        apply_regs(4095, 4095, 0, 2048, 0, 4095, 16, 16'hFFFF);
        run_ticks(MIX_CLEAN, 30);
        apply_random_regs();
        run_ticks(MIX_MIXED, 60);

        wait_drained();
        repeat (DrainCycles) @(negedge clk);
        $display("Summary: %0d ticks under %0d register settings, %0d results compared.",
                 ticks_sent, settings_run, compared);
        $display("Covered faults, timeouts, gear limits, crossed limits and settle ceiling.");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
